// ----- rtl/f8dq_pkg.sv -----
// Shared types and constants for the FP8 E4M3 to FP16 dequantizer.
package f8dq_pkg;

	localparam int unsigned Lanes = 4;
	localparam logic [15:0] HalfInf = 16'h7C00;
	localparam logic [15:0] HalfQnan = 16'h7E00;
	localparam logic [15:0] HalfSign = 16'h8000;

	// Per-lane product terms handed from the multiply stage to the round stage.
	typedef struct packed {
		logic        sgn;
		logic        force_nan;
		logic        force_inf;
		logic        zero;
		logic [11:0] mant;
		logic signed [8:0] expo;
	} f8dq_prod_t;

endpackage

// ----- rtl/f8dq_lane.sv -----
// One dequantizer lane: decode and multiply, register, then normalize and round.
module f8dq_lane
	import f8dq_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  logic [7:0]  code,
	input  logic [15:0] scale,
	output logic [15:0] half
);

	logic [3:0] ce;
	logic [2:0] cm;
	logic [7:0] se;
	logic [6:0] sm;
	logic [3:0] a;
	logic [7:0] b;
	f8dq_prod_t prod;
	f8dq_prod_t prod_s1;

	// Decode the operands and form the exact significand product.
	always_comb begin
		ce = code[6:3];
		cm = code[2:0];
		se = scale[14:7];
		sm = scale[6:0];
		a = (ce != 4'd0) ? {1'b1, cm} : {1'b0, cm};
		b = (se != 8'd0) ? {1'b1, sm} : {1'b0, sm};
		prod.sgn = code[7] ^ scale[15];
		prod.force_nan = (code[6:0] == 7'h7F) || (se == 8'hFF && sm != 7'd0)
			|| (se == 8'hFF && a == 4'd0);
		prod.force_inf = (se == 8'hFF);
		prod.mant = 12'(a) * 12'(b);
		prod.zero = (prod.mant == 12'd0);
		prod.expo = ((ce != 4'd0) ? 9'(signed'({1'b0, ce})) - 9'sd10 : -9'sd9)
			+ ((se != 8'd0) ? 9'(signed'({1'b0, se})) - 9'sd134 : -9'sd133);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
		end
	end

	logic [3:0] p;
	logic signed [9:0] q;
	logic signed [9:0] sh;
	logic [23:0] wide;
	logic [11:0] rem;
	logic [11:0] hlf;
	logic [11:0] n;
	logic [15:0] bits;

	// Find the leading one, place the result ulp, and round to nearest even.
	// A zero product is signed zero before any overflow test.
	always_comb begin
		p = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (prod_s1.mant[i]) begin
				p = 4'(i);
			end
		end
		q = 10'(signed'({1'b0, p})) + 10'(prod_s1.expo) - 10'sd10;
		if (q < -10'sd24) begin
			q = -10'sd24;
		end
		sh = q - 10'(prod_s1.expo);
		wide = 24'd0;
		rem = 12'd0;
		hlf = 12'd0;
		n = 12'd0;
		if (sh <= 10'sd0) begin
			n = prod_s1.mant << 4'(-sh);
		end else if (sh <= 10'sd13) begin
			wide = {prod_s1.mant, 12'd0} >> 5'(sh);
			n = wide[23:12];
			rem = wide[11:0];
			hlf = 12'h800;
			if (rem > hlf || (rem == hlf && n[0])) begin
				n = n + 12'd1;
			end
		end
		bits = (16'(q + 10'sd24) << 10) + 16'(n);
		if (prod_s1.force_nan) begin
			half = {prod_s1.sgn, HalfQnan[14:0]};
		end else if (prod_s1.zero) begin
			half = {prod_s1.sgn, 15'd0};
		end else if (prod_s1.force_inf || q >= 10'sd6 || bits >= HalfInf) begin
			half = {prod_s1.sgn, HalfInf[14:0]};
		end else begin
			half = {prod_s1.sgn, bits[14:0]};
		end
	end

endmodule

// ----- rtl/fp8_dequant_to_fp16.sv -----
// Top level of the four-lane FP8 E4M3 to FP16 dequantizer.
//   channel   dir  handshake          payload
//   s_axis    in   tvalid/tready      tdata codes, tuser row_out_of_range
//   m_axis    out  tvalid/tready      tdata half0..half3
//   scale     in   scale_we           scale_wdata
// One request per cycle while m_axis is not stalled; data passes the multiply stage, then the round stage.
// The four lanes share the scale register and advance together.
// Reset clears the valid bits and loads the scale with 1.0.
// A stalled output holds both stages; s_axis_tready follows the output stage.
module fp8_dequant_to_fp16
	import f8dq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        scale_we,
	input  logic [15:0] scale_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // code0, code1, code2, code3
	input  logic        s_axis_tuser,  // row_out_of_range
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // half0, half1, half2, half3
);

	logic [15:0] scale_q;
	logic        v_s1;
	logic        bad_s1;
	logic        adv;
	logic [15:0] half [Lanes];

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// Scale register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 16'h3F80;
		end else if (scale_we) begin
			scale_q <= scale_wdata;
		end
	end

	// Valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			m_axis_tvalid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad_s1 <= s_axis_tuser;
		end
	end

	// Lanes, then merge the four halves into the output register, zeroed when row_out_of_range was set.
	for (genvar k = 0; k < Lanes; k++) begin : g_lane
		f8dq_lane u_lane (
			.clk   (clk),
			.en    (adv),
			.code  (s_axis_tdata[8*k +: 8]),
			.scale (scale_q),
			.half  (half[k])
		);
		always_ff @(posedge clk) begin
			if (adv) begin
				m_axis_tdata[16*k +: 16] <= bad_s1 ? 16'd0 : half[k];
			end
		end
	end

endmodule
